// ===== rtl/fir_filter_32x16_top_macros.svh =====
// ---------------------------------------------------------------------------
// FIR filter assertion macros
// Shared forms for the concurrent assertions of the FIR filter checker.
// ---------------------------------------------------------------------------
`ifndef FIR_FILTER_32X16_TOP_MACROS_SVH
`define FIR_FILTER_32X16_TOP_MACROS_SVH

// Assertion that is switched off while reset is high.
`define FIR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define FIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fir_pkg.sv =====
// ---------------------------------------------------------------------------
// FIR filter package
// Field widths, register indexes, request codes and control bundles.
// ---------------------------------------------------------------------------
package fir_pkg;

   localparam int MAX_TAPS_DEF = 256;

   localparam int SAMPLE_W   = 32;
   localparam int COEF_W     = 16;
   localparam int IDX_W      = 8;
   localparam int TAPCNT_W   = 9;
   localparam int SHIFT_W    = 6;
   localparam int ACC_W      = 64;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_SHIFT = CSR_IDX_W'(1);

   localparam logic OP_COEF   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic clear;
      logic issue;
      logic live;
      logic hist_wr;
      logic coef_wr;
   } mac_ctrl_type;

   typedef struct packed {
      logic scale_en;
      logic abs_en;
   } post_ctrl_type;

endpackage

// ===== rtl/fir_mac.sv =====
// ---------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Holds the delay line and coefficient memories and runs one shared
// 32x16 multiplier into a 64-bit accumulator, one tap per cycle.
// ---------------------------------------------------------------------------
module fir_mac #(
   parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fir_pkg::mac_ctrl_type                 ctrl,
   input  logic [$clog2(MAX_TAPS)-1:0]           hist_addr,
   input  logic [$clog2(MAX_TAPS)-1:0]           coef_addr,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   hist_wdata,
   input  logic signed [fir_pkg::COEF_W-1:0]     coef_wdata,
   output logic                                  busy,
   output logic signed [fir_pkg::ACC_W-1:0]      acc
);
   import fir_pkg::*;

   logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
   logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic                       live_ff;
   logic                       rd_valid_ff, rd_valid_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_valid_ff, prod_valid_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] hist_op;

   always_ff @(posedge clock) begin
      if (ctrl.hist_wr) begin
         hist_mem[hist_addr] <= hist_wdata;
      end
      if (ctrl.coef_wr) begin
         coef_mem[coef_addr] <= coef_wdata;
      end
      hist_rd_ff <= hist_mem[hist_addr];
      coef_rd_ff <= coef_mem[coef_addr];
   end

   // Delay line entries never filled since reset count as zero.
   always_comb begin
      hist_op       = live_ff ? hist_rd_ff : '0;
      prod_in       = hist_op * coef_rd_ff;
      rd_valid_in   = ctrl.issue;
      prod_valid_in = rd_valid_ff;
      acc_in        = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W-1){prod_ff[PROD_W-1]}}, prod_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      live_ff <= ctrl.live;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy = rd_valid_ff | prod_valid_ff;
   assign acc  = acc_ff;

endmodule

// ===== rtl/fir_post.sv =====
// ---------------------------------------------------------------------------
// FIR output scaler
// Shifts the accumulator right, or left with saturation, then rounds half away from zero
// to a saturated Q1.31 sample over two register stages.
// ---------------------------------------------------------------------------
module fir_post (
   input  logic                                 clock,
   input  fir_pkg::post_ctrl_type               ctrl,
   input  logic signed [fir_pkg::ACC_W-1:0]     acc,
   input  logic signed [fir_pkg::SHIFT_W-1:0]   shift,
   output logic signed [fir_pkg::SAMPLE_W-1:0]  result
);
   import fir_pkg::*;

   localparam logic [ACC_W-1:0]    POS_MAX_64 = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0]    NEG_MAX_64 = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] POS_MAX_32 = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] NEG_MAX_32 = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [ACC_W-1:0]    HALF_LSB   = ACC_W'(32'h8000);

   logic [SHIFT_W-1:0]       lsh;
   logic [ACC_W-1:0]         hi_u;
   logic signed [ACC_W-1:0]  hi, lo;
   logic signed [ACC_W-1:0]  scaled_ff, scaled_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff;
   logic [ACC_W-1:0]         rsum;
   logic [ACC_W-17:0]        rq;
   logic                     over;

   always_comb begin
      lsh  = SHIFT_W'(0) - $unsigned(shift);
      hi_u = POS_MAX_64 >> lsh;
      hi   = $signed(hi_u);
      lo   = ~hi;
      if (!shift[SHIFT_W-1]) begin
         scaled_in = acc >>> shift[SHIFT_W-2:0];
      end else if (acc > hi) begin
         scaled_in = $signed(POS_MAX_64);
      end else if (acc < lo) begin
         scaled_in = $signed(NEG_MAX_64);
      end else begin
         scaled_in = acc <<< lsh;
      end
      mag_in = scaled_ff[ACC_W-1] ? (ACC_W'(0) - $unsigned(scaled_ff))
                                  : $unsigned(scaled_ff);
      rsum   = mag_ff + HALF_LSB;
      rq     = rsum[ACC_W-1:16];
      over   = |rq[ACC_W-17:SAMPLE_W-1];
      if (neg_ff) begin
         result = over ? $signed(NEG_MAX_32) : $signed(SAMPLE_W'(0) - rq[SAMPLE_W-1:0]);
      end else begin
         result = over ? $signed(POS_MAX_32) : $signed(rq[SAMPLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         scaled_ff <= scaled_in;
      end
      if (ctrl.abs_en) begin
         mag_ff <= mag_in;
         neg_ff <= scaled_ff[ACC_W-1];
      end
   end

endmodule

// ===== rtl/fir_filter_32x16_top.sv =====
// ---------------------------------------------------------------------------
// FIR filter 32x16 top level
// A filtered request with n taps in use runs its n taps through the shared
// multiply-accumulate loop at one tap per cycle in MAC, then passes DRAIN,
// SCALE, ABS, RND and OUT before its response is registered; the next
// request is taken once the block is back in IDLE. A bypassed sample goes
// straight to OUT, and coefficient writes are taken every cycle while idle.
// Synchronous reset clears the state, settings, write position and fill count.
// ---------------------------------------------------------------------------
module fir_filter_32x16_top #(
   parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [fir_pkg::IDX_W-1:0]             req_coef_index,
   input  logic signed [fir_pkg::COEF_W-1:0]     req_coef_value,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fir_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_write_en,
   input  logic [fir_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fir_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import fir_pkg::*;

   localparam int AW = $clog2(MAX_TAPS);
   localparam int CW = $clog2(MAX_TAPS + 1);
   localparam logic [AW:0]   DEPTH_A = (AW+1)'(MAX_TAPS);
   localparam logic [CW-1:0] DEPTH_C = CW'(MAX_TAPS);
   localparam logic [AW-1:0] LAST_A  = AW'(MAX_TAPS - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MAC   = 7'b0000010,
      ST_DRAIN = 7'b0000100,
      ST_SCALE = 7'b0001000,
      ST_ABS   = 7'b0010000,
      ST_RND   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [TAPCNT_W-1:0]       tap_count_ff, tap_count_in;
   logic signed [SHIFT_W-1:0] shift_ff, shift_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [CW-1:0]             k_ff, k_in;
   logic [CW-1:0]             n_ff, n_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0]               n_wide;
   logic [CW-1:0]             n_eff;
   logic                      bypass;
   logic                      accept;
   logic [AW-1:0]             wp_dec;
   logic [CW-1:0]             fill_inc;
   logic [AW:0]               rd_sum, rd_wrap;
   logic                      last_k;
   logic [AW-1:0]             hist_addr, coef_addr;

   mac_ctrl_type              mac_ctrl;
   post_ctrl_type             post_ctrl;
   logic                      mac_busy;
   logic signed [ACC_W-1:0]   mac_acc;
   logic signed [SAMPLE_W-1:0] post_result;

   always_comb begin
      n_wide   = (32'(tap_count_ff) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tap_count_ff);
      n_eff    = {n_wide[CW-1:2], 2'b00};
      bypass   = (n_eff[CW-1:2] == '0);
      accept   = req_valid && req_ready;
      wp_dec   = (wp_ff == '0) ? LAST_A : wp_ff - AW'(1);
      fill_inc = (fill_ff == DEPTH_C) ? fill_ff : fill_ff + CW'(1);
      rd_sum   = {1'b0, wp_ff} + {1'b0, k_ff[AW-1:0]};
      rd_wrap  = (rd_sum >= DEPTH_A) ? rd_sum - DEPTH_A : rd_sum;
      last_k   = (k_ff == n_ff - CW'(1));

      hist_addr = (state_ff == ST_IDLE) ? wp_dec : rd_wrap[AW-1:0];
      coef_addr = (state_ff == ST_IDLE) ? AW'(req_coef_index) : k_ff[AW-1:0];

      mac_ctrl.clear   = accept && (req_op == OP_SAMPLE) && !bypass;
      mac_ctrl.hist_wr = accept && (req_op == OP_SAMPLE) && !bypass;
      mac_ctrl.coef_wr = accept && (req_op == OP_COEF)
                         && (32'(req_coef_index) < 32'(MAX_TAPS));
      mac_ctrl.issue   = (state_ff == ST_MAC);
      mac_ctrl.live    = (k_ff < fill_ff);

      post_ctrl.scale_en = (state_ff == ST_SCALE);
      post_ctrl.abs_en   = (state_ff == ST_ABS);
   end

   always_comb begin
      state_in     = state_ff;
      tap_count_in = tap_count_ff;
      shift_in     = shift_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_TAP_COUNT: begin
               tap_count_in = csr_wdata[TAPCNT_W-1:0];
            end
            CSR_RIGHT_SHIFT: begin
               shift_in = $signed(csr_wdata[SHIFT_W-1:0]);
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_SAMPLE)) begin
               if (bypass) begin
                  res_in   = req_sample_in;
                  state_in = ST_OUT;
               end else begin
                  wp_in    = wp_dec;
                  fill_in  = fill_inc;
                  k_in     = '0;
                  n_in     = n_eff;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            k_in = k_ff + CW'(1);
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            res_in   = post_result;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= '0;
         shift_ff     <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         shift_ff     <= shift_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      n_ff        <= n_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   fir_mac #(
      .MAX_TAPS (MAX_TAPS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .hist_addr  (hist_addr),
      .coef_addr  (coef_addr),
      .hist_wdata (req_sample_in),
      .coef_wdata (req_coef_value),
      .busy       (mac_busy),
      .acc        (mac_acc)
   );

   fir_post u_post (
      .clock  (clock),
      .ctrl   (post_ctrl),
      .acc    (mac_acc),
      .shift  (shift_ff),
      .result (post_result)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// ===== rtl/fir_chk.sv =====
// ---------------------------------------------------------------------------
// FIR filter port checker
// Watches the top level's ports for handshake and sequencing errors.
// ---------------------------------------------------------------------------
`include "fir_filter_32x16_top_macros.svh"

module fir_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_op,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [fir_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
   import fir_pkg::*;

   `FIR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped before it was taken")
   `FIR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample_out), "stalled response changed")
   `FIR_ASSERT(a_busy_after_sample, clock, reset, req_valid && req_ready && (req_op == OP_SAMPLE) |=> !req_ready, "sample request did not make the block busy")
   `FIR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind fir_filter_32x16_top fir_chk u_fir_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

// ===== bench/tb_fir_filter_32x16_top.sv =====
// ---------------------------------------------------------------------------
// FIR filter 32x16 regression bench
// Drives coefficient writes and samples through the request channel and
// checks every filtered response against a bit-exact predictor kept in the
// bench. A short directed part covers bypass, rounding halves, saturation and
// truncated tap counts; random phases then sweep tap counts and scaling
// under varying request and response back-pressure.
// ---------------------------------------------------------------------------
module tb_fir_filter_32x16_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fir_pkg::*;

   localparam int LONG_STALL   = 400;
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_PHASES   = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(15);

   typedef struct {
      logic                       op;
      logic [IDX_W-1:0]           coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMPLE_W-1:0] sample_in;
   } fir_request_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_op = OP_COEF;
   logic [IDX_W-1:0]           req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   fir_request_type            req_queue[$];
   fir_request_type            req_cur;
   bit                         req_busy;
   logic signed [SAMPLE_W-1:0] sample_out_due[$];

   logic signed [SAMPLE_W-1:0] hist_mem[MAX_TAPS_DEF] = '{default: '0};
   logic signed [COEF_W-1:0]   coef_mem[MAX_TAPS_DEF] = '{default: '0};
   logic [IDX_W-1:0]           wr_pos = '0;
   logic [TAPCNT_W-1:0]        tap_cfg = '0;
   logic signed [SHIFT_W-1:0]  shift_cfg = '0;
   bit                         coef_loaded[MAX_TAPS_DEF];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_asks;
   int unsigned stall_taken;
   int unsigned stall_left;
   int unsigned fail_count;
   int unsigned checked_count;
   int unsigned coef_count;
   int unsigned filtered_count;
   int unsigned bypass_count;
   int unsigned setting_count;

   int phase_taps[NUM_PHASES]  = '{8, 16, 4, 12, 32, 511, 256, 20, 6, 0, 64, 24};
   int phase_shift[NUM_PHASES] = '{0, 2, -31, -4, 5, 31, -1, 0, 1, 3, 8, -16};
   int phase_items[NUM_PHASES] = '{150, 150, 60, 150, 150, 15, 15, 150, 60, 60, 100, 150};

   fir_filter_32x16_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned used_taps();
      int unsigned n;
      n = (tap_cfg > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_cfg;
      return n & ~32'd3;
   endfunction

   function automatic longint scale_sum(longint a, int s);
      longint top;
      longint hi;
      longint lo;
      top = longint'(64'h7FFF_FFFF_FFFF_FFFF);
      if (s > 0) begin
         return a >>> s;
      end
      if (s < 0) begin
         hi = top >>> (-s);
         lo = -hi - 1;
         if (a > hi) begin
            return top;
         end
         if (a < lo) begin
            return -top - 1;
         end
         return a <<< (-s);
      end
      return a;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] round_to_q31(longint a);
      bit        neg;
      bit [63:0] mag;
      bit [63:0] r;
      neg = a < 0;
      mag = neg ? -$unsigned(a) : $unsigned(a);
      r = (mag + 64'h8000) >> 16;
      if (neg) begin
         if (r >= 64'h8000_0000) begin
            return 32'sh8000_0000;
         end
         return -r[31:0];
      end
      if (r > 64'h7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      return r[31:0];
   endfunction

   task automatic apply_request(input fir_request_type r);
      int unsigned n;
      longint      acc;
      logic [IDX_W-1:0] p;
      if (r.op == OP_COEF) begin
         coef_mem[r.coef_index] = r.coef_value;
         coef_count++;
         return;
      end
      n = used_taps();
      if (n < 4) begin
         sample_out_due.push_back(r.sample_in);
         bypass_count++;
         return;
      end
      wr_pos = wr_pos - 1'b1;
      hist_mem[wr_pos] = r.sample_in;
      acc = 0;
      for (int k = 0; k < n; k++) begin
         p = wr_pos + IDX_W'(k);
         acc += longint'(hist_mem[p]) * longint'(coef_mem[k]) * 2;
      end
      sample_out_due.push_back(round_to_q31(scale_sum(acc, int'(shift_cfg))));
      filtered_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_busy = 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            apply_request(req_cur);
         end
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_cur = req_queue.pop_front();
            req_valid <= 1'b1;
            req_op <= req_cur.op;
            req_coef_index <= req_cur.coef_index;
            req_coef_value <= req_cur.coef_value;
            req_sample_in <= req_cur.sample_in;
            req_busy = 1'b1;
         end else begin
            req_valid <= 1'b0;
            req_busy = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sample_out_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("ERROR: unexpected response sample_out=%h at %0t",
                           rsp_sample_out, $realtime);
               end
            end else begin
               want = sample_out_due.pop_front();
               checked_count++;
               if (rsp_sample_out !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("ERROR: response %0d sample_out expected %h actual %h at %0t",
                              checked_count, want, rsp_sample_out, $realtime);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_taken != stall_asks) begin
            stall_taken = stall_asks;
            stall_left = LONG_STALL;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(15))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         4: return SAMPLE_W'($signed(16'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      logic signed [COEF_W-1:0] v;
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         default: begin
            v = COEF_W'($urandom);
            return v >>> $urandom_range(7);
         end
      endcase
   endfunction

   task automatic queue_coef(input int unsigned idx, input logic signed [COEF_W-1:0] val);
      fir_request_type r;
      r.op = OP_COEF;
      r.coef_index = IDX_W'(idx);
      r.coef_value = val;
      r.sample_in = $urandom;
      coef_loaded[idx] = 1'b1;
      req_queue.push_back(r);
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_W-1:0] x);
      fir_request_type r;
      r.op = OP_SAMPLE;
      r.coef_index = IDX_W'($urandom);
      r.coef_value = COEF_W'($urandom);
      r.sample_in = x;
      req_queue.push_back(r);
   endtask

   task automatic wait_idle();
      int unsigned settle;
      while (req_queue.size() != 0 || req_busy || sample_out_due.size() != 0) begin
         @(posedge clock);
      end
      settle = used_taps() + 16;
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_TAP_COUNT) begin
         tap_cfg = val[TAPCNT_W-1:0];
      end else if (idx == CSR_RIGHT_SHIFT) begin
         shift_cfg = val[SHIFT_W-1:0];
      end
   endtask

   task automatic set_filter(input int taps, input int shift_val);
      logic [CSR_DATA_W-1:0] wd;
      logic [31:0]           sv;
      wait_idle();
      sv = shift_val;
      wd = '0;
      wd[SHIFT_W-1:0] = sv[SHIFT_W-1:0];
      write_csr(CSR_TAP_COUNT, CSR_DATA_W'(taps));
      write_csr(CSR_RIGHT_SHIFT, wd);
      setting_count++;
      for (int i = 0; i < used_taps(); i++) begin
         if (!coef_loaded[i]) begin
            queue_coef(i, rand_coef());
         end
      end
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15) begin
            queue_coef($urandom_range(MAX_TAPS_DEF - 1), rand_coef());
         end else begin
            queue_sample(rand_sample());
         end
      end
   endtask

   initial begin
      #20_000_000;
      $display("fir_filter_32x16_top regression: fail");
      $finish;
   end

   initial begin
      send_idle_pct = 27;
      recv_idle_pct = 49;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_SPARE, '1);
      set_filter(0, 0);
      queue_sample('0);
      queue_sample(32'sh7FFF_FFFF);
      queue_sample(32'sh8000_0000);
      queue_sample('1);
      queue_coef(0, 16'sd1);
      queue_coef(1, '0);
      queue_coef(2, '0);
      queue_coef(3, '0);
      queue_coef(MAX_TAPS_DEF - 1, 16'sh8000);

      set_filter(7, 0);
      queue_sample(32'sh0000_4000);
      queue_sample(-32'sh0000_4000);
      queue_sample(32'sh0000_3FFF);
      queue_sample(32'sh7FFF_FFFF);
      queue_coef(0, 16'sh7FFF);
      queue_coef(1, 16'sh8000);
      queue_coef(2, 16'sh7FFF);
      queue_coef(3, 16'sh8000);

      set_filter(4, -31);
      queue_sample(32'sh7FFF_FFFF);
      queue_sample(32'sh8000_0000);
      queue_sample(32'sh7FFF_FFFF);
      queue_sample(32'sh8000_0000);

      set_filter(4, 31);
      queue_sample(32'sh8000_0000);
      queue_sample(32'sh7FFF_FFFF);

      set_filter(3, -1);
      queue_sample(32'sh0000_0001);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_filter(phase_taps[ph], phase_shift[ph]);
         if (ph == 4) begin
            send_idle_pct = 49;
            recv_idle_pct = 27;
         end else if (ph == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random(phase_items[ph]);
         if (ph == 1) begin
            stall_asks++;
         end
      end
      wait_idle();

      $display("Run covered %0d coefficient writes, %0d filtered and %0d bypassed samples",
               coef_count, filtered_count, bypass_count);
      $display("over %0d filter settings; %0d responses checked, %0d failures.",
               setting_count, checked_count, fail_count);
      if (fail_count == 0) begin
         $display("fir_filter_32x16_top regression: pass");
      end else begin
         $display("fir_filter_32x16_top regression: fail");
      end
      $finish;
   end

endmodule
